// File: sv/varint_length_prefix_deframer_unit_assert.svh
// Assertion macros for the deframer
`ifndef VARINT_LENGTH_PREFIX_DEFRAMER_UNIT_ASSERT_SVH
`define VARINT_LENGTH_PREFIX_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define VLPD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VLPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/vlpd_pkg.sv
`timescale 1ns / 1ps

package vlpd_pkg;

   localparam int LEN_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int GROUP_BITS = 7;
   localparam int GI_W       = 3;
   localparam int GI_MAX     = 7;
   localparam int SHAMT_W    = 6;
   localparam int SPREAD_W   = GROUP_BITS + GROUP_BITS * GI_MAX;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd512;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   typedef struct packed {
      logic              in_payload;
      logic [LEN_W-1:0]  length_sum;
      logic [GI_W-1:0]   group_index;
      logic [LEN_W-1:0]  bytes_remaining;
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] data;
      logic              last;
   } result_type;

endpackage

// File: sv/vlpd_step.sv
`timescale 1ns / 1ps

module vlpd_step #(
   parameter int LENGTH_BITS = 16
) (
   input  vlpd_pkg::state_type              state_i,
   input  logic [vlpd_pkg::BYTE_W-1:0]      byte_i,
   input  logic [vlpd_pkg::LEN_W-1:0]       max_i,
   output vlpd_pkg::state_type              state_o,
   output vlpd_pkg::result_type             res_o,
   output logic                             res_valid_o
);

   localparam int CHK_BITS = (LENGTH_BITS < vlpd_pkg::LEN_W) ? LENGTH_BITS : vlpd_pkg::LEN_W;

   logic [vlpd_pkg::SHAMT_W-1:0]  shamt;
   logic [vlpd_pkg::SPREAD_W-1:0] add_wide;
   logic [vlpd_pkg::LEN_W:0]      sum;
   logic                          err;
   logic [vlpd_pkg::LEN_W-1:0]    rem_dec;

   assign shamt    = vlpd_pkg::SHAMT_W'(state_i.group_index) *
                     vlpd_pkg::SHAMT_W'(vlpd_pkg::GROUP_BITS);
   assign add_wide = vlpd_pkg::SPREAD_W'(byte_i[vlpd_pkg::GROUP_BITS-1:0]) << shamt;
   assign sum      = {1'b0, state_i.length_sum} + {1'b0, add_wide[vlpd_pkg::LEN_W-1:0]};
   // group bits past the counter or past the 16-bit register, or a sum above max_i, fail
   assign err      = (|add_wide[vlpd_pkg::SPREAD_W-1:CHK_BITS]) || (sum > {1'b0, max_i});
   assign rem_dec  = (state_i.bytes_remaining != '0) ?
                     state_i.bytes_remaining - vlpd_pkg::LEN_W'(1) : '0;

   always_comb begin
      state_o     = state_i;
      res_o       = '0;
      res_valid_o = 1'b0;
      if (state_i.in_payload) begin
         res_valid_o = 1'b1;
         res_o.kind  = vlpd_pkg::KIND_PAYLOAD;
         res_o.data  = byte_i;
         res_o.last  = (state_i.bytes_remaining <= vlpd_pkg::LEN_W'(1));
         state_o.bytes_remaining = rem_dec;
         if (rem_dec == '0) begin
            state_o = '0;
         end
      end else if (err) begin
         state_o     = '0;
         res_valid_o = 1'b1;
         res_o.kind  = vlpd_pkg::KIND_ERROR;
      end else begin
         state_o.length_sum  = sum[vlpd_pkg::LEN_W-1:0];
         state_o.group_index = (state_i.group_index != vlpd_pkg::GI_W'(vlpd_pkg::GI_MAX)) ?
                               state_i.group_index + vlpd_pkg::GI_W'(1) : state_i.group_index;
         if (!byte_i[vlpd_pkg::BYTE_W-1]) begin
            if (sum[vlpd_pkg::LEN_W-1:0] == '0) begin
               state_o     = '0;
               res_valid_o = 1'b1;
               res_o.kind  = vlpd_pkg::KIND_EMPTY;
            end else begin
               state_o                 = '0;
               state_o.in_payload      = 1'b1;
               state_o.bytes_remaining = sum[vlpd_pkg::LEN_W-1:0];
            end
         end
      end
   end

endmodule

// File: sv/varint_length_prefix_deframer_unit.sv
`timescale 1ns / 1ps

// Base-128 varint length-prefixed deframer. One stream byte per cycle is
// accepted and processed, sustained while the result side is ready; a byte
// is captured in the input register at its transfer and its result is loaded
// into the result register once that register is empty or being taken.
// Header bytes with no error that do not end an empty frame give no result;
// otherwise each byte gives one result: payload byte (last marked), empty
// frame, or length error. The csr_max_frame_length write (reset 512) applies
// from the next header byte and is to be written while the block is idle.
`include "varint_length_prefix_deframer_unit_assert.svh"

module varint_length_prefix_deframer_unit #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [vlpd_pkg::BYTE_W-1:0]      req_stream_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_result_kind,
   output logic [vlpd_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic                             rsp_last_of_frame,
   input  logic                             csr_write_enable,
   input  logic [vlpd_pkg::LEN_W-1:0]       csr_max_frame_length
);

   vlpd_pkg::state_type           state_ff, state_in;
   vlpd_pkg::result_type          rsp_ff, rsp_in, step_res;
   logic [vlpd_pkg::LEN_W-1:0]    max_ff, max_in;
   logic                          in_valid_ff, in_valid_in;
   logic [vlpd_pkg::BYTE_W-1:0]   in_byte_ff, in_byte_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   vlpd_pkg::state_type           step_state;
   logic                          step_valid;
   logic                          proc;

   vlpd_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .state_i     (state_ff),
      .byte_i      (in_byte_ff),
      .max_i       (max_ff),
      .state_o     (step_state),
      .res_o       (step_res),
      .res_valid_o (step_valid)
   );

   assign proc      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc;

   always_comb begin
      max_in       = csr_write_enable ? csr_max_frame_length : max_ff;
      in_valid_in  = (req_valid && req_ready) ? 1'b1 : (proc ? 1'b0 : in_valid_ff);
      in_byte_in   = (req_valid && req_ready) ? req_stream_byte : in_byte_ff;
      state_in     = proc ? step_state : state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (proc) begin
         rsp_valid_in = step_valid;
         rsp_in       = step_res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         max_ff       <= vlpd_pkg::MAX_LEN_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_ff.kind;
   assign rsp_payload_byte  = rsp_ff.data;
   assign rsp_last_of_frame = rsp_ff.last;

   `VLPD_ASSERT_NOW(a_payload_has_count, clock, reset, state_ff.in_payload, state_ff.bytes_remaining != '0, "payload state with zero count")
   `VLPD_ASSERT_NOW(a_header_no_count, clock, reset, !state_ff.in_payload, state_ff.bytes_remaining == '0, "header state with leftover count")
   `VLPD_ASSERT_NOW(a_last_is_payload, clock, reset, rsp_valid_ff && rsp_ff.last, rsp_ff.kind == vlpd_pkg::KIND_PAYLOAD, "last flag on non-payload result")
   `VLPD_ASSERT_NEXT(a_payload_end, clock, reset, proc && state_ff.in_payload && state_ff.bytes_remaining == vlpd_pkg::LEN_W'(1), rsp_valid_ff && rsp_ff.last && !state_ff.in_payload, "final payload byte not closing frame")

endmodule

// File: tb/sv/tb_varint_length_prefix_deframer_unit.sv
`timescale 1ns / 1ps

class frame_scoreboard;
   logic [vlpd_pkg::LEN_W-1:0] max_len;
   bit                         in_payload;
   logic [16:0]                length_sum;
   logic [vlpd_pkg::GI_W-1:0]  group_index;
   logic [vlpd_pkg::LEN_W-1:0] bytes_remaining;
   vlpd_pkg::result_type       pending[$];
   int                         errors;

   function new();
      max_len = vlpd_pkg::MAX_LEN_RESET;
      errors  = 0;
      restart();
   endfunction

   function void restart();
      in_payload      = 1'b0;
      length_sum      = '0;
      group_index     = '0;
      bytes_remaining = '0;
   endfunction

   // predicts the result of one accepted stream byte
   function void note_byte(logic [7:0] b);
      vlpd_pkg::result_type r;
      logic [63:0]          add;
      logic [63:0]          sum;
      bit                   emit;
      r    = '0;
      emit = 1'b0;
      if (in_payload) begin
         r.kind = vlpd_pkg::KIND_PAYLOAD;
         r.data = b;
         r.last = (bytes_remaining <= 1);
         emit   = 1'b1;
         if (bytes_remaining > 0) bytes_remaining--;
         if (bytes_remaining == 0) restart();
      end else begin
         add = 64'(b[vlpd_pkg::GROUP_BITS-1:0]) << (vlpd_pkg::GROUP_BITS * group_index);
         sum = 64'(length_sum) + add;
         if ((add >> vlpd_pkg::LEN_W) != 0 || sum > 64'(max_len)) begin
            restart();
            r.kind = vlpd_pkg::KIND_ERROR;
            emit   = 1'b1;
         end else begin
            length_sum = sum[16:0];
            if (group_index < vlpd_pkg::GI_MAX) group_index++;
            if (!b[7]) begin
               if (length_sum == 0) begin
                  restart();
                  r.kind = vlpd_pkg::KIND_EMPTY;
                  emit   = 1'b1;
               end else begin
                  bytes_remaining = length_sum[vlpd_pkg::LEN_W-1:0];
                  in_payload      = 1'b1;
                  length_sum      = '0;
                  group_index     = '0;
               end
            end
         end
      end
      if (emit) pending.push_back(r);
   endfunction

   function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      vlpd_pkg::result_type exp_r;
      if (pending.size() == 0) begin
         $error("unexpected result: kind %0d data %0d last %0d", kind, data, last);
         errors++;
         return;
      end
      exp_r = pending.pop_front();
      if (kind !== exp_r.kind) begin
         $error("result_kind: expected %0d actual %0d", exp_r.kind, kind);
         errors++;
      end
      if (data !== exp_r.data) begin
         $error("payload_byte: expected %0d actual %0d", exp_r.data, data);
         errors++;
      end
      if (last !== exp_r.last) begin
         $error("last_of_frame: expected %0d actual %0d", exp_r.last, last);
         errors++;
      end
   endfunction
endclass

module tb_varint_length_prefix_deframer_unit;

   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 220;
   localparam int LONG_HOLD   = 300;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [vlpd_pkg::BYTE_W-1:0]   req_stream_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_result_kind;
   logic [vlpd_pkg::BYTE_W-1:0]   rsp_payload_byte;
   logic                          rsp_last_of_frame;
   logic                          csr_write_enable = 1'b0;
   logic [vlpd_pkg::LEN_W-1:0]    csr_max_frame_length = '0;

   frame_scoreboard   sb;
   bit                idle_on = 1'b1;
   bit                want_hold = 1'b0;
   int                rsp_stall_left = 0;
   int                items_sent = 0;

   varint_length_prefix_deframer_unit #(
      .LENGTH_BITS(vlpd_pkg::LEN_W)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_stream_byte     (req_stream_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .csr_write_enable    (csr_write_enable),
      .csr_max_frame_length(csr_max_frame_length)
   );

   always #2 clock = ~clock;

   // result side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (want_hold) begin
         want_hold      = 1'b0;
         rsp_stall_left = LONG_HOLD;
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_result_kind, rsp_payload_byte, rsp_last_of_frame);
   end

   // called right after a rising edge; returns right after the transfer edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b);
      items_sent++;
   endtask

   task automatic send_seq(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [vlpd_pkg::LEN_W-1:0] v);
      wait_idle();
      csr_max_frame_length <= v;
      csr_write_enable     <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.max_len = v;
   endtask

   // one frame: well-formed, oversize/overflow header, or a stray byte
   task automatic send_frame();
      logic [7:0]  hdr[$];
      int unsigned max_len;
      int unsigned len;
      int unsigned cap;
      int          pad;
      int          pick;
      max_len = sb.max_len;
      pick    = $urandom_range(0, 99);
      hdr.delete();
      if (pick < 10) begin
         send_byte(8'($urandom));
      end else if (pick < 25) begin
         if (max_len > 65535 - 301 || $urandom_range(0, 2) == 0) begin
            hdr.push_back(8'h80 | 8'($urandom_range(0, 127)));
            hdr.push_back(8'h80 | 8'($urandom_range(0, 127)));
            hdr.push_back({1'($urandom), 7'($urandom_range(4, 127))});
         end else begin
            len = max_len + 1 + $urandom_range(0, 300);
            do begin
               hdr.push_back({1'b1, 7'(len)});
               len = len >> 7;
            end while (len != 0);
            hdr[hdr.size()-1][7] = 1'b0;
         end
         send_seq(hdr);
      end else begin
         cap = ($urandom_range(0, 19) == 0) ? 300 : 24;
         if (cap > max_len) cap = max_len;
         len = $urandom_range(0, cap);
         pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
         do begin
            hdr.push_back({1'b1, 7'(len)});
            len = len >> 7;
         end while (len != 0);
         repeat (pad) hdr.push_back(8'h80);
         hdr[hdr.size()-1][7] = 1'b0;
         send_seq(hdr);
      end
      // close any open header, then drain the open payload
      if (!sb.in_payload && (sb.group_index != 0 || sb.length_sum != 0))
         send_byte(8'h00);
      while (sb.in_payload) send_byte(8'($urandom));
   endtask

   initial begin
      logic [7:0]                 seq[$];
      logic [vlpd_pkg::LEN_W-1:0] phase_max[PHASES];
      int                         phase_end;
      sb = new();
      phase_max = '{16'd0, 16'd65535, 16'd1, vlpd_pkg::MAX_LEN_RESET,
                    vlpd_pkg::LEN_W'($urandom_range(2, 65534)),
                    vlpd_pkg::LEN_W'($urandom_range(2, 40)),
                    16'd300};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty frame, one-byte frame, oversize on a second header byte
      seq = '{8'h00, 8'h01, 8'hA5, 8'h81, 8'h04};
      send_seq(seq);
      // group beyond the counter
      seq = '{8'h80, 8'h80, 8'h04};
      send_seq(seq);
      // saturated group index: nonzero group overflows, zero groups are empty
      seq = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01};
      send_seq(seq);
      seq = '{8'h80, 8'h80, 8'h00, 8'hFF, 8'h7F};
      send_seq(seq);

      for (int p = 0; p < PHASES; p++) begin
         write_max_len(phase_max[p]);
         if (p == 0) begin
            seq = '{8'h01, 8'h00, 8'h80};
            send_seq(seq);
         end
         if (p == 1) want_hold = 1'b1;
         if (p == PHASES - 1) idle_on = 1'b0;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) send_frame();
      end

      wait_idle();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/vlpd_pkg.sv
sv/vlpd_step.sv
sv/varint_length_prefix_deframer_unit.sv
tb/sv/tb_varint_length_prefix_deframer_unit.sv
